### hdl/wpp_pkg.sv
package wpp_pkg;

    localparam logic [31:0] HEADER_WORD = 32'h00BE11E2;
    localparam logic [31:0] WAVE_TYPE   = 32'h77617665;

    // wide enough for 511 * 128 + 128
    localparam int IDX_W = 17;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    localparam logic [1:0] MODE_STREAM    = 2'd0;
    localparam logic [1:0] MODE_PED_WRITE = 2'd1;
    localparam logic [1:0] MODE_PED_CLEAR = 2'd2;

    localparam logic [1:0] CMD_WORD      = 2'd0;
    localparam logic [1:0] CMD_PED_WRITE = 2'd1;
    localparam logic [1:0] CMD_PED_CLEAR = 2'd2;

    localparam logic [1:0] RES_SAMPLE    = 2'd0;
    localparam logic [1:0] RES_MISSING   = 2'd1;
    localparam logic [1:0] RES_TRUNCATED = 2'd2;
    localparam logic [1:0] RES_OVERSIZE  = 2'd3;

    // one classified item: a pedestal operation or the results of one word
    typedef struct packed {
        logic [1:0]       kind;
        logic [15:0]      header;
        logic [31:0]      evt;
        logic [11:0]      raw0;
        logic [11:0]      raw1;
        logic [IDX_W-1:0] idx0;
        logic             has_pair;
        logic             last_pair;
        logic             missing;
        logic             oversize;
        logic             truncated;
        logic [11:0]      ped_addr;
        logic [15:0]      ped_value;
    } t_cmd;

    typedef struct packed {
        logic push;
        t_cmd cmd;
    } t_cmd_push;

    typedef struct packed {
        logic empty;
        t_cmd cmd;
    } t_cmd_head;

    typedef struct packed {
        logic init_busy;
        logic clearing;
    } t_back_status;

endpackage

### hdl/wpp_front.sv
module wpp_front #(
    parameter int SPW  = 64,
    parameter int MAXW = 512,
    parameter int PE   = 4096
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_mode,
    input  logic [31:0]         i_word,
    input  logic                i_end_of_buffer,
    input  logic [11:0]         i_ped_address,
    input  logic [15:0]         i_ped_value,
    output wpp_pkg::t_cmd_push  o_push
);
    import wpp_pkg::*;

    localparam logic [3:0] PH_HUNT   = 4'd0;
    localparam logic [3:0] PH_LEN    = 4'd1;
    localparam logic [3:0] PH_TYPE   = 4'd2;
    localparam logic [3:0] PH_BOARD  = 4'd3;
    localparam logic [3:0] PH_REFWIN = 4'd4;
    localparam logic [3:0] PH_EVENT  = 4'd5;
    localparam logic [3:0] PH_COUNT  = 4'd6;
    localparam logic [3:0] PH_WFHDR  = 4'd7;
    localparam logic [3:0] PH_WFLEN  = 4'd8;
    localparam logic [3:0] PH_SAMP   = 4'd9;

    localparam int SI_W  = $clog2(SPW + 1);
    localparam int SWL_W = $clog2(SPW / 2 + 1);

    localparam logic [31:0]      SPW_LIM  = 32'(SPW);
    localparam logic [31:0]      MAXW_LIM = 32'(MAXW);
    localparam logic [IDX_W-1:0] PED_LIM  = IDX_W'(PE);

    logic [3:0]       r_phase, n_phase;
    logic [9:0]       r_wf_left, n_wf_left;
    logic [SWL_W-1:0] r_words_left, n_words_left;
    logic             r_odd, n_odd;
    logic [SI_W-1:0]  r_sidx, n_sidx;
    logic [15:0]      r_header, n_header;
    logic [31:0]      r_event, n_event;
    logic [IDX_W-1:0] r_base, n_base;

    logic [9:0]       wf_dec;
    logic [SWL_W-1:0] wl_dec;
    t_cmd_push        push;

    assign wf_dec = r_wf_left - {9'd0, r_wf_left != 10'd0};
    assign wl_dec = r_words_left - SWL_W'(r_words_left != '0);

    always_comb begin
        n_phase      = r_phase;
        n_wf_left    = r_wf_left;
        n_words_left = r_words_left;
        n_odd        = r_odd;
        n_sidx       = r_sidx;
        n_header     = r_header;
        n_event      = r_event;
        n_base       = r_base;
        push         = '0;
        if (i_accept) begin
            case (i_mode)
                MODE_PED_WRITE: begin
                    if (IDX_W'(i_ped_address) < PED_LIM) begin
                        push.push          = 1'b1;
                        push.cmd.kind      = CMD_PED_WRITE;
                        push.cmd.ped_addr  = i_ped_address;
                        push.cmd.ped_value = i_ped_value;
                    end
                end
                MODE_PED_CLEAR: begin
                    push.push     = 1'b1;
                    push.cmd.kind = CMD_PED_CLEAR;
                end
                MODE_STREAM: begin
                    case (r_phase)
                        PH_LEN:    n_phase = PH_TYPE;
                        PH_TYPE:   n_phase = (i_word == WAVE_TYPE) ? PH_BOARD : PH_HUNT;
                        PH_BOARD:  n_phase = PH_REFWIN;
                        PH_REFWIN: n_phase = PH_EVENT;
                        PH_EVENT: begin
                            n_event = i_word;
                            n_phase = PH_COUNT;
                        end
                        PH_COUNT: begin
                            if (i_word == 32'd0 || i_word > MAXW_LIM) begin
                                n_phase = PH_HUNT;
                            end else begin
                                n_wf_left = i_word[9:0];
                                n_phase   = PH_WFHDR;
                            end
                        end
                        PH_WFHDR: begin
                            n_header = i_word[15:0];
                            n_base   = IDX_W'(i_word[8:0]) * IDX_W'(SPW);
                            n_phase  = PH_WFLEN;
                        end
                        PH_WFLEN: begin
                            if (i_word > SPW_LIM) begin
                                push.cmd.oversize = 1'b1;
                                n_wf_left         = 10'd0;
                                n_phase           = PH_HUNT;
                            end else begin
                                n_odd        = i_word[0];
                                n_sidx       = '0;
                                n_words_left = SWL_W'(i_word >> 1);
                                if (i_word[31:1] == 31'd0) begin
                                    // zero or one sample: no sample words follow
                                    push.cmd.missing = i_word[0];
                                    n_wf_left        = wf_dec;
                                    n_phase          = (wf_dec != 10'd0) ? PH_WFHDR : PH_HUNT;
                                end else begin
                                    n_phase = PH_SAMP;
                                end
                            end
                        end
                        PH_SAMP: begin
                            push.cmd.has_pair  = 1'b1;
                            push.cmd.last_pair = (r_words_left <= SWL_W'(1)) && !r_odd;
                            n_sidx             = r_sidx + SI_W'(2);
                            n_words_left       = wl_dec;
                            if (wl_dec == '0) begin
                                push.cmd.missing = r_odd;
                                n_wf_left        = wf_dec;
                                n_phase          = (wf_dec != 10'd0) ? PH_WFHDR : PH_HUNT;
                            end
                        end
                        default: n_phase = (i_word == HEADER_WORD) ? PH_LEN : PH_HUNT;
                    endcase
                    if (i_end_of_buffer && n_phase != PH_HUNT) begin
                        push.cmd.truncated = 1'b1;
                        n_wf_left          = 10'd0;
                        n_words_left       = '0;
                        n_phase            = PH_HUNT;
                    end
                    push.cmd.kind   = CMD_WORD;
                    push.cmd.header = n_header;
                    push.cmd.evt    = n_event;
                    push.cmd.raw0   = i_word[11:0];
                    push.cmd.raw1   = i_word[27:16];
                    push.cmd.idx0   = (r_phase == PH_SAMP) ? r_base + IDX_W'(r_sidx) : r_base;
                    push.push       = push.cmd.has_pair | push.cmd.missing |
                                      push.cmd.oversize | push.cmd.truncated;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_wf_left    <= 10'd0;
            r_words_left <= '0;
            r_odd        <= 1'b0;
            r_sidx       <= '0;
            r_header     <= 16'd0;
            r_event      <= 32'd0;
            r_base       <= '0;
        end else begin
            r_phase      <= n_phase;
            r_wf_left    <= n_wf_left;
            r_words_left <= n_words_left;
            r_odd        <= n_odd;
            r_sidx       <= n_sidx;
            r_header     <= n_header;
            r_event      <= n_event;
            r_base       <= n_base;
        end
    end

    assign o_push = push;

endmodule

### hdl/wpp_cmd_fifo.sv
module wpp_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wpp_pkg::t_cmd_push  i_push,
    input  logic                i_pop,
    output wpp_pkg::t_cmd_head  o_head,
    output logic                o_full
);
    import wpp_pkg::*;

    t_cmd               r_q [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wp, r_rp;
    logic [CMD_PTR_W:0]   r_cnt;
    logic                 wr, rd;

    assign wr = i_push.push;
    assign rd = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= i_push.cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + CMD_PTR_W'(1);
            end
            if (rd) begin
                r_rp <= r_rp + CMD_PTR_W'(1);
            end
            r_cnt <= r_cnt + (CMD_PTR_W + 1)'(wr) - (CMD_PTR_W + 1)'(rd);
        end
    end

    assign o_head.empty = (r_cnt == '0);
    assign o_head.cmd   = r_q[r_rp];
    assign o_full       = (r_cnt == (CMD_PTR_W + 1)'(CMD_DEPTH));

endmodule

### hdl/wpp_back.sv
module wpp_back #(
    parameter int PE = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wpp_pkg::t_cmd_head     i_head,
    output logic                   o_pop,
    output wpp_pkg::t_back_status  o_bstat,
    input  logic                   i_res_pop,
    output logic                   o_res_empty,
    output logic [14:0]            o_res_position,
    output logic [15:0]            o_res_header,
    output logic [31:0]            o_res_event,
    output logic [11:0]            o_res_raw,
    output logic signed [16:0]     o_res_corrected,
    output logic                   o_res_last,
    output logic [1:0]             o_res_status
);
    import wpp_pkg::*;

    localparam int AW        = $clog2(PE);
    localparam int OUT_DEPTH = 4;
    localparam int OPTR_W    = $clog2(OUT_DEPTH);

    localparam logic [IDX_W-1:0] PED_LIM = IDX_W'(PE);

    typedef struct packed {
        logic [14:0] pos;
        logic [15:0] header;
        logic [31:0] evt;
        logic [11:0] raw;
        logic        last_wf;
        logic [1:0]  status;
        logic        is_samp;
        logic        ped_zero;
    } t_issue;

    typedef struct packed {
        logic [14:0] pos;
        logic [15:0] header;
        logic [31:0] evt;
        logic [11:0] raw;
        logic [16:0] corr;
        logic        last_wf;
        logic [1:0]  status;
    } t_res;

    logic [15:0]     r_mem [PE];
    logic [15:0]     r_ped_q;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [15:0]     wdata;
    logic [AW-1:0]   raddr;

    logic            r_clearing, n_clearing;
    logic            r_init, n_init;
    logic [AW-1:0]   r_ccnt, n_ccnt;
    logic [1:0]      r_slot, n_slot;

    t_issue          r_p, n_p;
    logic            r_p_valid, n_p_valid;

    t_res            r_oq [OUT_DEPTH];
    logic [OPTR_W-1:0] r_owp, r_orp;
    logic [OPTR_W:0]   r_ocnt;
    logic            owr, ord;
    t_res            res;

    logic [3:0]       v;
    logic [1:0]       sel;
    logic             more;
    logic             room;
    logic             pop;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] miss_idx;

    // slots of one word: first sample, second sample, missing or oversize, truncation
    always_comb begin
        v[0] = i_head.cmd.has_pair;
        v[1] = i_head.cmd.has_pair;
        v[2] = i_head.cmd.missing | i_head.cmd.oversize;
        // with a pair and a missing sample the truncation takes over the third result
        v[3] = i_head.cmd.truncated && !(i_head.cmd.has_pair && i_head.cmd.missing);
        sel  = 2'd0;
        for (int i = 3; i >= 0; i--) begin
            if (v[i] && 2'(i) >= r_slot) begin
                sel = 2'(i);
            end
        end
        more = 1'b0;
        for (int j = 0; j < 4; j++) begin
            if (v[j] && 2'(j) > sel) begin
                more = 1'b1;
            end
        end
    end

    assign room     = (r_ocnt + (OPTR_W + 1)'(r_p_valid)) < (OPTR_W + 1)'(OUT_DEPTH);
    assign miss_idx = i_head.cmd.has_pair ? i_head.cmd.idx0 + IDX_W'(2) : i_head.cmd.idx0;

    always_comb begin
        n_p        = r_p;
        n_p.header = i_head.cmd.header;
        n_p.evt    = i_head.cmd.evt;
        idx        = i_head.cmd.idx0;
        case (sel)
            2'd0: begin
                idx         = i_head.cmd.idx0;
                n_p.raw     = i_head.cmd.raw0;
                n_p.last_wf = 1'b0;
                n_p.status  = RES_SAMPLE;
                n_p.is_samp = 1'b1;
            end
            2'd1: begin
                idx         = i_head.cmd.idx0 + IDX_W'(1);
                n_p.raw     = i_head.cmd.raw1;
                n_p.last_wf = i_head.cmd.last_pair;
                n_p.status  = RES_SAMPLE;
                n_p.is_samp = 1'b1;
            end
            2'd2: begin
                idx         = i_head.cmd.oversize ? '0 : miss_idx;
                n_p.raw     = 12'd0;
                n_p.last_wf = 1'b1;
                n_p.is_samp = 1'b0;
                if (i_head.cmd.oversize) begin
                    n_p.status = RES_OVERSIZE;
                end else if (i_head.cmd.has_pair && i_head.cmd.truncated) begin
                    n_p.status = RES_TRUNCATED;
                end else begin
                    n_p.status = RES_MISSING;
                end
            end
            default: begin
                idx         = '0;
                n_p.raw     = 12'd0;
                n_p.last_wf = 1'b0;
                n_p.status  = RES_TRUNCATED;
                n_p.is_samp = 1'b0;
            end
        endcase
        n_p.pos      = idx[14:0];
        n_p.ped_zero = (idx >= PED_LIM);
    end

    assign raddr = idx[AW-1:0];

    always_comb begin
        n_clearing = r_clearing;
        n_init     = r_init;
        n_ccnt     = r_ccnt;
        n_slot     = r_slot;
        n_p_valid  = 1'b0;
        pop        = 1'b0;
        we         = 1'b0;
        waddr      = r_ccnt;
        wdata      = 16'd0;
        if (r_clearing) begin
            we = 1'b1;
            if (r_ccnt == AW'(PE - 1)) begin
                n_clearing = 1'b0;
                n_init     = 1'b0;
                n_ccnt     = '0;
            end else begin
                n_ccnt = r_ccnt + AW'(1);
            end
        end else if (!i_head.empty) begin
            case (i_head.cmd.kind)
                CMD_WORD: begin
                    if (room) begin
                        n_p_valid = 1'b1;
                        pop       = !more;
                        n_slot    = more ? sel + 2'd1 : 2'd0;
                    end
                end
                CMD_PED_WRITE: begin
                    we    = 1'b1;
                    waddr = AW'(i_head.cmd.ped_addr);
                    wdata = i_head.cmd.ped_value;
                    pop   = 1'b1;
                end
                CMD_PED_CLEAR: begin
                    n_clearing = 1'b1;
                    n_ccnt     = '0;
                    pop        = 1'b1;
                end
                default: pop = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_ped_q <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        r_p <= n_p;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_init     <= 1'b1;
            r_ccnt     <= '0;
            r_slot     <= 2'd0;
            r_p_valid  <= 1'b0;
        end else begin
            r_clearing <= n_clearing;
            r_init     <= n_init;
            r_ccnt     <= n_ccnt;
            r_slot     <= n_slot;
            r_p_valid  <= n_p_valid;
        end
    end

    // second stage: pedestal data has arrived
    always_comb begin
        res.pos     = r_p.pos;
        res.header  = r_p.header;
        res.evt     = r_p.evt;
        res.raw     = r_p.raw;
        res.last_wf = r_p.last_wf;
        res.status  = r_p.status;
        if (r_p.is_samp) begin
            res.corr = {1'b0, r_p.raw, 4'd0} - (r_p.ped_zero ? 17'd0 : {1'b0, r_ped_q});
        end else begin
            res.corr = 17'd0;
        end
    end

    assign owr = r_p_valid;
    assign ord = i_res_pop && (r_ocnt != '0);

    always_ff @(posedge i_clk) begin
        if (owr) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (owr) begin
                r_owp <= r_owp + OPTR_W'(1);
            end
            if (ord) begin
                r_orp <= r_orp + OPTR_W'(1);
            end
            r_ocnt <= r_ocnt + (OPTR_W + 1)'(owr) - (OPTR_W + 1)'(ord);
        end
    end

    assign o_pop              = pop;
    assign o_bstat.init_busy  = r_init;
    assign o_bstat.clearing   = r_clearing;
    assign o_res_empty        = (r_ocnt == '0);
    assign o_res_position     = r_oq[r_orp].pos;
    assign o_res_header       = r_oq[r_orp].header;
    assign o_res_event        = r_oq[r_orp].evt;
    assign o_res_raw          = r_oq[r_orp].raw;
    assign o_res_corrected    = $signed(r_oq[r_orp].corr);
    assign o_res_last         = r_oq[r_orp].last_wf;
    assign o_res_status       = r_oq[r_orp].status;

endmodule

### hdl/waveform_packet_parser.sv
// a word goes through the command queue, issue register and pedestal read, and result queue
// throughput: one word per cycle into a 4-deep queue while full is low; results leave at one
// per cycle while the result queue has room, set by the single read port of the pedestal
// memory, so the two samples of a word are issued one after the other
// a pedestal write is one memory write; a table clear zeroes every entry in the back end
// reset (synchronous, active low) starts a clearing pass, during which full stays high
module waveform_packet_parser #(
    parameter int SAMPLES_PER_WAVEFORM = 64,
    parameter int MAX_WAVEFORMS        = 512,
    parameter int PEDESTAL_ENTRIES     = 4096
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_mode,
    input  logic [31:0]        i_word,
    input  logic               i_end_of_buffer,
    input  logic [11:0]        i_ped_address,
    input  logic [15:0]        i_ped_value,
    output logic               empty,
    input  logic               pop,
    output logic [14:0]        o_sample_position,
    output logic [8:0]         o_window,
    output logic [1:0]         o_asic_column,
    output logic [1:0]         o_asic_row,
    output logic [2:0]         o_asic_channel,
    output logic [31:0]        o_event_number,
    output logic [11:0]        o_raw_sample,
    output logic signed [16:0] o_corrected_sample,
    output logic               o_last_of_waveform,
    output logic [1:0]         o_status
);
    import wpp_pkg::*;

    t_cmd_push    w_cmd_push;
    t_cmd_head    w_cmd_head;
    t_back_status w_bstat;
    logic         w_cmd_full;
    logic         w_cmd_pop;
    logic         w_accept;
    logic [15:0]  w_header;

    assign full     = w_cmd_full | w_bstat.init_busy;
    assign w_accept = push && !full;

    wpp_front #(
        .SPW  (SAMPLES_PER_WAVEFORM),
        .MAXW (MAX_WAVEFORMS),
        .PE   (PEDESTAL_ENTRIES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_mode          (i_mode),
        .i_word          (i_word),
        .i_end_of_buffer (i_end_of_buffer),
        .i_ped_address   (i_ped_address),
        .i_ped_value     (i_ped_value),
        .o_push          (w_cmd_push)
    );

    wpp_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_pop   (w_cmd_pop),
        .o_head  (w_cmd_head),
        .o_full  (w_cmd_full)
    );

    wpp_back #(
        .PE (PEDESTAL_ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (w_cmd_head),
        .o_pop           (w_cmd_pop),
        .o_bstat         (w_bstat),
        .i_res_pop       (pop),
        .o_res_empty     (empty),
        .o_res_position  (o_sample_position),
        .o_res_header    (w_header),
        .o_res_event     (o_event_number),
        .o_res_raw       (o_raw_sample),
        .o_res_corrected (o_corrected_sample),
        .o_res_last      (o_last_of_waveform),
        .o_res_status    (o_status)
    );

    assign o_window       = w_header[8:0];
    assign o_asic_column  = w_header[15:14];
    assign o_asic_row     = w_header[13:12];
    assign o_asic_channel = w_header[11:9];

    // queue between front and back never written while full
    a_no_cmd_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push.push |-> !w_cmd_full)
        else $error("command queue written while full");

    a_no_pop_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_head.empty)
        else $error("command queue popped while empty");

    a_clear_holds_queue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.clearing |-> !w_cmd_pop)
        else $error("item taken from queue during clearing pass");

    a_no_result_in_init : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bstat.init_busy |-> empty)
        else $error("result offered before the pedestal table is cleared");

    a_filler_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == RES_MISSING || o_status == RES_OVERSIZE)) |->
        (o_last_of_waveform && o_raw_sample == 12'd0 && o_corrected_sample == 17'sd0))
        else $error("missing or oversize result carries sample data");

endmodule

### verif/tb_waveform_packet_parser.sv
`timescale 1ns / 1ps

module tb_waveform_packet_parser;

    import wpp_pkg::*;

    localparam int SAMPLES_PER_WAVEFORM = 64;
    localparam int MAX_WAVEFORMS        = 512;
    localparam int PEDESTAL_ENTRIES     = 4096;
    localparam int CYCLE_LIMIT          = 600000;
    localparam int SETTLE_CYCLES        = 16;
    localparam int MAX_REPORTS          = 40;

    // mode code with no meaning, the block ignores it
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef enum logic [3:0] {
        HUNT_HEADER, SKIP_LENGTH, CHECK_TYPE, SKIP_BOARD, SKIP_REFWIN,
        TAKE_EVENT, TAKE_COUNT, TAKE_WF_HEADER, TAKE_WF_LENGTH, TAKE_SAMPLES
    } t_wave_parse;

    typedef struct {
        logic [14:0]        pos;
        logic [8:0]         win;
        logic [1:0]         col;
        logic [1:0]         row;
        logic [2:0]         chan;
        logic [31:0]        evt;
        logic [11:0]        raw;
        logic signed [16:0] corr;
        logic               last;
        logic [1:0]         status;
    } t_sample_rec;

    logic               i_clk;
    logic               i_rst_n;
    logic               push;
    logic               full;
    logic [1:0]         i_mode;
    logic [31:0]        i_word;
    logic               i_end_of_buffer;
    logic [11:0]        i_ped_address;
    logic [15:0]        i_ped_value;
    logic               empty;
    logic               pop;
    logic [14:0]        o_sample_position;
    logic [8:0]         o_window;
    logic [1:0]         o_asic_column;
    logic [1:0]         o_asic_row;
    logic [2:0]         o_asic_channel;
    logic [31:0]        o_event_number;
    logic [11:0]        o_raw_sample;
    logic signed [16:0] o_corrected_sample;
    logic               o_last_of_waveform;
    logic [1:0]         o_status;

    // predictor state
    t_wave_parse parse_state;
    int          waveforms_left;
    int          sample_words_left;
    int          sample_count;
    int          sample_idx;
    logic [15:0] cur_header;
    logic [31:0] cur_event;
    logic [15:0] ped_tbl [PEDESTAL_ENTRIES];

    t_sample_rec pending_samples [$];
    t_sample_rec oldest;

    int errors;
    int results_checked;
    int useful_items;
    int items_sent;
    int clears_sent;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    waveform_packet_parser #(
        .SAMPLES_PER_WAVEFORM (SAMPLES_PER_WAVEFORM),
        .MAX_WAVEFORMS        (MAX_WAVEFORMS),
        .PEDESTAL_ENTRIES     (PEDESTAL_ENTRIES)
    ) u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_mode             (i_mode),
        .i_word             (i_word),
        .i_end_of_buffer    (i_end_of_buffer),
        .i_ped_address      (i_ped_address),
        .i_ped_value        (i_ped_value),
        .empty              (empty),
        .pop                (pop),
        .o_sample_position  (o_sample_position),
        .o_window           (o_window),
        .o_asic_column      (o_asic_column),
        .o_asic_row         (o_asic_row),
        .o_asic_channel     (o_asic_channel),
        .o_event_number     (o_event_number),
        .o_raw_sample       (o_raw_sample),
        .o_corrected_sample (o_corrected_sample),
        .o_last_of_waveform (o_last_of_waveform),
        .o_status           (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles with %0d results outstanding",
                     $time, cycle_count, pending_samples.size());
            $display("waveform_packet_parser verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic t_sample_rec build_rec(logic [14:0] pos, logic [11:0] raw,
                                              logic [16:0] corr, logic last,
                                              logic [1:0] status);
        t_sample_rec r;
        r.pos    = pos;
        r.win    = cur_header[8:0];
        r.col    = cur_header[15:14];
        r.row    = cur_header[13:12];
        r.chan   = cur_header[11:9];
        r.evt    = cur_event;
        r.raw    = raw;
        r.corr   = corr;
        r.last   = last;
        r.status = status;
        return r;
    endfunction

    function automatic int sample_slot();
        return cur_header[8:0] * SAMPLES_PER_WAVEFORM + sample_idx;
    endfunction

    function automatic t_sample_rec correct_sample(logic [11:0] raw, logic last);
        int          idx;
        logic [15:0] ped;
        logic [16:0] corr;
        idx  = sample_slot();
        ped  = (idx < PEDESTAL_ENTRIES) ? ped_tbl[idx] : 16'd0;
        corr = {1'b0, raw, 4'b0000} - {1'b0, ped};
        sample_idx++;
        return build_rec(idx[14:0], raw, corr, last, RES_SAMPLE);
    endfunction

    function automatic t_sample_rec missing_rec();
        int idx;
        idx = sample_slot();
        return build_rec(idx[14:0], 12'd0, 17'd0, 1'b1, RES_MISSING);
    endfunction

    function automatic void close_waveform();
        if (waveforms_left > 0)
            waveforms_left--;
        parse_state = (waveforms_left > 0) ? TAKE_WF_HEADER : HUNT_HEADER;
    endfunction

    function automatic void predict_samples(logic [1:0] mode, logic [31:0] w, logic eob,
                                            logic [11:0] addr, logic [15:0] val);
        t_sample_rec res [3];
        int          n;
        logic        odd;
        logic        final_word;
        n = 0;
        if (mode == MODE_PED_WRITE) begin
            ped_tbl[addr] = val;
            return;
        end
        if (mode == MODE_PED_CLEAR) begin
            foreach (ped_tbl[i])
                ped_tbl[i] = 16'd0;
            return;
        end
        if (mode != MODE_STREAM)
            return;

        case (parse_state)
            SKIP_LENGTH: parse_state = CHECK_TYPE;
            CHECK_TYPE:  parse_state = (w == WAVE_TYPE) ? SKIP_BOARD : HUNT_HEADER;
            SKIP_BOARD:  parse_state = SKIP_REFWIN;
            SKIP_REFWIN: parse_state = TAKE_EVENT;
            TAKE_EVENT: begin
                cur_event   = w;
                parse_state = TAKE_COUNT;
            end
            TAKE_COUNT: begin
                if (w == 0 || w > MAX_WAVEFORMS) begin
                    parse_state = HUNT_HEADER;
                end else begin
                    waveforms_left = w;
                    parse_state    = TAKE_WF_HEADER;
                end
            end
            TAKE_WF_HEADER: begin
                cur_header  = w[15:0];
                parse_state = TAKE_WF_LENGTH;
            end
            TAKE_WF_LENGTH: begin
                if (w > SAMPLES_PER_WAVEFORM) begin
                    res[n]         = build_rec(15'd0, 12'd0, 17'd0, 1'b1, RES_OVERSIZE);
                    n++;
                    waveforms_left = 0;
                    parse_state    = HUNT_HEADER;
                end else begin
                    sample_count      = w;
                    sample_idx        = 0;
                    sample_words_left = w / 2;
                    if (sample_words_left == 0) begin
                        if (w == 1) begin
                            res[n] = missing_rec();
                            n++;
                        end
                        close_waveform();
                    end else begin
                        parse_state = TAKE_SAMPLES;
                    end
                end
            end
            TAKE_SAMPLES: begin
                final_word = (sample_words_left <= 1);
                odd        = sample_count[0];
                res[n]     = correct_sample(w[11:0], 1'b0);
                n++;
                res[n]     = correct_sample(w[27:16], final_word && !odd);
                n++;
                if (sample_words_left > 0)
                    sample_words_left--;
                if (sample_words_left == 0) begin
                    if (odd) begin
                        res[n] = missing_rec();
                        n++;
                    end
                    close_waveform();
                end
            end
            default: parse_state = (w == HEADER_WORD) ? SKIP_LENGTH : HUNT_HEADER;
        endcase

        // end of buffer with a packet still open
        if (eob && parse_state != HUNT_HEADER) begin
            if (n < 3) begin
                res[n] = build_rec(15'd0, 12'd0, 17'd0, 1'b0, RES_TRUNCATED);
                n++;
            end else begin
                res[2].raw    = 12'd0;
                res[2].corr   = 17'sd0;
                res[2].status = RES_TRUNCATED;
            end
            waveforms_left    = 0;
            sample_words_left = 0;
            parse_state       = HUNT_HEADER;
        end

        for (int k = 0; k < n; k++)
            pending_samples.insert(pending_samples.size(), res[k]);
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic send_item(input logic [1:0] mode, input logic [31:0] w, input logic eob,
                             input logic [11:0] addr, input logic [15:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            push = 1'b0;
        end
        @(negedge i_clk);
        push            = 1'b1;
        i_mode          = mode;
        i_word          = w;
        i_end_of_buffer = eob;
        i_ped_address   = addr;
        i_ped_value     = val;
        forever begin
            @(posedge i_clk);
            if (!full)
                break;
        end
        predict_samples(mode, w, eob, addr, val);
        items_sent++;
    endtask

    task automatic send_word(input logic [31:0] w, input logic eob);
        logic [11:0] a;
        logic [15:0] v;
        a = 12'($urandom);
        v = 16'($urandom);
        send_item(MODE_STREAM, w, eob, a, v);
        useful_items++;
    endtask

    task automatic write_pedestal(input logic [11:0] addr, input logic [15:0] val);
        send_item(MODE_PED_WRITE, $urandom, 1'($urandom_range(1)), addr, val);
        useful_items++;
    endtask

    task automatic clear_pedestals();
        logic [11:0] a;
        logic [15:0] v;
        a = 12'($urandom);
        v = 16'($urandom);
        send_item(MODE_PED_CLEAR, $urandom, 1'($urandom_range(1)), a, v);
        useful_items++;
        clears_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push = 1'b0;
        while (pending_samples.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // receiver: random stalls plus an optional long hold-off
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                pop = 1'b0;
                hold_cycles--;
            end else begin
                pop = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string nm, input longint want, input longint got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_samples.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, got position %0d status %0d",
                             $time, o_sample_position, o_status);
            end else begin
                oldest = pending_samples.pop_front();
                check_field("sample_position", oldest.pos, o_sample_position);
                check_field("window", oldest.win, o_window);
                check_field("asic_column", oldest.col, o_asic_column);
                check_field("asic_row", oldest.row, o_asic_row);
                check_field("asic_channel", oldest.chan, o_asic_channel);
                check_field("event_number", oldest.evt, o_event_number);
                check_field("raw_sample", oldest.raw, o_raw_sample);
                check_field("corrected_sample", oldest.corr, o_corrected_sample);
                check_field("last_of_waveform", oldest.last, o_last_of_waveform);
                check_field("status", oldest.status, o_status);
            end
            results_checked++;
        end
    end

    // ---------------------------------------------------------------- stimulus

    function automatic logic pick_eob();
        return ($urandom_range(99) < 2);
    endfunction

    function automatic logic [31:0] pick_wf_count();
        int r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(3, 1);
        if (r < 80) return 32'd0;
        if (r < 88) return $urandom_range(1023, MAX_WAVEFORMS + 1);
        if (r < 92) return $urandom;
        if (r < 96) return MAX_WAVEFORMS;
        return $urandom_range(8, 4);
    endfunction

    function automatic logic [31:0] pick_sample_count();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 32'd0;
        if (r < 20) return 32'd1;
        if (r < 75) return $urandom_range(9, 2);
        if (r < 81) return SAMPLES_PER_WAVEFORM;
        if (r < 85) return SAMPLES_PER_WAVEFORM - 1;
        if (r < 93) return $urandom_range(127, SAMPLES_PER_WAVEFORM + 1);
        return $urandom;
    endfunction

    task automatic send_random_waveform();
        logic [31:0] w;
        w = $urandom;
        // most windows land inside the pedestal table
        w[8:0] = ($urandom_range(3) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(63));
        send_word(w, pick_eob());
        if (parse_state != TAKE_WF_LENGTH)
            return;
        send_word(pick_sample_count(), pick_eob());
        while (parse_state == TAKE_SAMPLES)
            send_word($urandom, pick_eob());
    endtask

    task automatic send_random_packet();
        logic [31:0] w;
        for (int step = 0; step < 7; step++) begin
            case (step)
                0:       w = HEADER_WORD;
                2:       w = ($urandom_range(9) == 0) ? $urandom : WAVE_TYPE;
                6:       w = pick_wf_count();
                default: w = $urandom;
            endcase
            send_word(w, pick_eob());
            if (parse_state == HUNT_HEADER)
                return;
        end
        for (int k = 0; k < 4 && parse_state == TAKE_WF_HEADER; k++)
            send_random_waveform();
        // cut long packets short with an end of buffer on the next header
        if (parse_state == TAKE_WF_HEADER)
            send_word($urandom, 1'b1);
    endtask

    task automatic test_pedestal_extremes();
        write_pedestal(12'd0, 16'hFFFF);
        write_pedestal(12'd1, 16'h0010);
        write_pedestal(12'hFFF, 16'h5A5A);
    endtask

    // odd count ending on the buffer end: the missing sample becomes the truncation
    task automatic test_odd_waveform_truncated();
        send_item(MODE_STREAM, 32'hFFFF_FFFF, 1'b0, 12'd0, 16'd0);
        send_word(HEADER_WORD, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(WAVE_TYPE, 1'b0);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'd2, 1'b0);
        send_word(32'h0000_FE00, 1'b0);
        send_word(32'd3, 1'b0);
        send_word(32'h0FFF_0000, 1'b1);
    endtask

    task automatic test_header_errors();
        send_word(HEADER_WORD, 1'b0);
        send_word(32'h0000_0010, 1'b0);
        send_word(WAVE_TYPE ^ 32'h1, 1'b0);
        send_word(HEADER_WORD, 1'b1);
        send_item(MODE_UNUSED, HEADER_WORD, 1'b1, 12'hFFF, 16'hFFFF);
        send_word(HEADER_WORD, 1'b0);
        send_word(32'h0000_0010, 1'b0);
        send_word(WAVE_TYPE, 1'b0);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'd1, 1'b0);
        send_word(32'h0000_01FF, 1'b0);
        send_word(SAMPLES_PER_WAVEFORM + 1, 1'b0);
        clear_pedestals();
    endtask

    task automatic test_random_stream(input int n_items);
        int target;
        int r;
        logic [11:0] a;
        target = useful_items + n_items;
        while (useful_items < target) begin
            r = $urandom_range(99);
            if (r < 6) begin
                a = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(1023));
                write_pedestal(a, 16'($urandom));
            end else if (r < 7 && clears_sent < 4) begin
                clear_pedestals();
            end else if (r < 10) begin
                // noise: an unused mode or a stray word while hunting
                send_item($urandom_range(1) ? MODE_UNUSED : MODE_STREAM, $urandom,
                          1'($urandom_range(1)), 12'($urandom), 16'($urandom));
            end else begin
                send_random_packet();
            end
        end
    endtask

    // receiver holds off while two full waveforms are offered
    task automatic test_back_pressure();
        logic [31:0] w;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 400;
        send_word(HEADER_WORD, 1'b0);
        send_word($urandom, 1'b0);
        send_word(WAVE_TYPE, 1'b0);
        send_word($urandom, 1'b0);
        send_word($urandom, 1'b0);
        send_word($urandom, 1'b0);
        send_word(32'd2, 1'b0);
        for (int k = 0; k < 2; k++) begin
            w      = $urandom;
            w[8:0] = 9'(k);
            send_word(w, 1'b0);
            send_word(SAMPLES_PER_WAVEFORM, 1'b0);
            repeat (SAMPLES_PER_WAVEFORM / 2) send_word($urandom, 1'b0);
        end
    endtask

    initial begin
        push            = 1'b0;
        i_mode          = MODE_STREAM;
        i_word          = 32'd0;
        i_end_of_buffer = 1'b0;
        i_ped_address   = 12'd0;
        i_ped_value     = 16'd0;
        i_rst_n         = 1'b0;
        errors          = 0;
        results_checked = 0;
        useful_items    = 0;
        items_sent      = 0;
        clears_sent     = 0;
        cycle_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_cycles     = 0;
        parse_state       = HUNT_HEADER;
        waveforms_left    = 0;
        sample_words_left = 0;
        sample_count      = 0;
        sample_idx        = 0;
        cur_header        = 16'd0;
        cur_event         = 32'd0;
        foreach (ped_tbl[i])
            ped_tbl[i] = 16'd0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_pedestal_extremes();
        test_odd_waveform_truncated();
        test_header_errors();
        wait_drained();

        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_stream(22);
        send_idle_pct = 87; recv_stall_pct = 0;
        test_random_stream(22);
        send_idle_pct = 0;  recv_stall_pct = 87;
        test_random_stream(22);
        send_idle_pct = 10; recv_stall_pct = 10;
        test_random_stream(22);
        wait_drained();

        test_back_pressure();
        @(negedge i_clk);
        push = 1'b0;
        wait_drained();

        if (pending_samples.size() != 0) begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_samples.size());
        end
        $display("%0d items sent (%0d parsed words or pedestal operations), %0d pedestal clears",
                 items_sent, useful_items, clears_sent);
        $display("%0d results checked over %0d cycles, %0d mismatches",
                 results_checked, cycle_count, errors);
        if (errors == 0) begin
            $display("waveform_packet_parser verification clean");
        end else begin
            $display("waveform_packet_parser verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/wpp_pkg.sv
hdl/wpp_front.sv
hdl/wpp_cmd_fifo.sv
hdl/wpp_back.sv
hdl/waveform_packet_parser.sv
verif/tb_waveform_packet_parser.sv
